### src/aes_pkg.sv
package aes_pkg;

	localparam int BlockWidth = 128;
	localparam int HalfWidth = 64;
	localparam int RoundCountDefault = 10;

	typedef logic [BlockWidth-1:0] block_t;
	typedef logic [7:0] byte_t;

	// Register indexes on the configuration port.
	localparam logic [0:0] RegKeyHigh = 1'b0;
	localparam logic [0:0] RegKeyLow = 1'b1;

	function automatic byte_t sbox(input byte_t v);
		byte_t r;
		case (v)
			8'h00: r = 8'h63; 8'h01: r = 8'h7c; 8'h02: r = 8'h77; 8'h03: r = 8'h7b;
			8'h04: r = 8'hf2; 8'h05: r = 8'h6b; 8'h06: r = 8'h6f; 8'h07: r = 8'hc5;
			8'h08: r = 8'h30; 8'h09: r = 8'h01; 8'h0a: r = 8'h67; 8'h0b: r = 8'h2b;
			8'h0c: r = 8'hfe; 8'h0d: r = 8'hd7; 8'h0e: r = 8'hab; 8'h0f: r = 8'h76;
			8'h10: r = 8'hca; 8'h11: r = 8'h82; 8'h12: r = 8'hc9; 8'h13: r = 8'h7d;
			8'h14: r = 8'hfa; 8'h15: r = 8'h59; 8'h16: r = 8'h47; 8'h17: r = 8'hf0;
			8'h18: r = 8'had; 8'h19: r = 8'hd4; 8'h1a: r = 8'ha2; 8'h1b: r = 8'haf;
			8'h1c: r = 8'h9c; 8'h1d: r = 8'ha4; 8'h1e: r = 8'h72; 8'h1f: r = 8'hc0;
			8'h20: r = 8'hb7; 8'h21: r = 8'hfd; 8'h22: r = 8'h93; 8'h23: r = 8'h26;
			8'h24: r = 8'h36; 8'h25: r = 8'h3f; 8'h26: r = 8'hf7; 8'h27: r = 8'hcc;
			8'h28: r = 8'h34; 8'h29: r = 8'ha5; 8'h2a: r = 8'he5; 8'h2b: r = 8'hf1;
			8'h2c: r = 8'h71; 8'h2d: r = 8'hd8; 8'h2e: r = 8'h31; 8'h2f: r = 8'h15;
			8'h30: r = 8'h04; 8'h31: r = 8'hc7; 8'h32: r = 8'h23; 8'h33: r = 8'hc3;
			8'h34: r = 8'h18; 8'h35: r = 8'h96; 8'h36: r = 8'h05; 8'h37: r = 8'h9a;
			8'h38: r = 8'h07; 8'h39: r = 8'h12; 8'h3a: r = 8'h80; 8'h3b: r = 8'he2;
			8'h3c: r = 8'heb; 8'h3d: r = 8'h27; 8'h3e: r = 8'hb2; 8'h3f: r = 8'h75;
			8'h40: r = 8'h09; 8'h41: r = 8'h83; 8'h42: r = 8'h2c; 8'h43: r = 8'h1a;
			8'h44: r = 8'h1b; 8'h45: r = 8'h6e; 8'h46: r = 8'h5a; 8'h47: r = 8'ha0;
			8'h48: r = 8'h52; 8'h49: r = 8'h3b; 8'h4a: r = 8'hd6; 8'h4b: r = 8'hb3;
			8'h4c: r = 8'h29; 8'h4d: r = 8'he3; 8'h4e: r = 8'h2f; 8'h4f: r = 8'h84;
			8'h50: r = 8'h53; 8'h51: r = 8'hd1; 8'h52: r = 8'h00; 8'h53: r = 8'hed;
			8'h54: r = 8'h20; 8'h55: r = 8'hfc; 8'h56: r = 8'hb1; 8'h57: r = 8'h5b;
			8'h58: r = 8'h6a; 8'h59: r = 8'hcb; 8'h5a: r = 8'hbe; 8'h5b: r = 8'h39;
			8'h5c: r = 8'h4a; 8'h5d: r = 8'h4c; 8'h5e: r = 8'h58; 8'h5f: r = 8'hcf;
			8'h60: r = 8'hd0; 8'h61: r = 8'hef; 8'h62: r = 8'haa; 8'h63: r = 8'hfb;
			8'h64: r = 8'h43; 8'h65: r = 8'h4d; 8'h66: r = 8'h33; 8'h67: r = 8'h85;
			8'h68: r = 8'h45; 8'h69: r = 8'hf9; 8'h6a: r = 8'h02; 8'h6b: r = 8'h7f;
			8'h6c: r = 8'h50; 8'h6d: r = 8'h3c; 8'h6e: r = 8'h9f; 8'h6f: r = 8'ha8;
			8'h70: r = 8'h51; 8'h71: r = 8'ha3; 8'h72: r = 8'h40; 8'h73: r = 8'h8f;
			8'h74: r = 8'h92; 8'h75: r = 8'h9d; 8'h76: r = 8'h38; 8'h77: r = 8'hf5;
			8'h78: r = 8'hbc; 8'h79: r = 8'hb6; 8'h7a: r = 8'hda; 8'h7b: r = 8'h21;
			8'h7c: r = 8'h10; 8'h7d: r = 8'hff; 8'h7e: r = 8'hf3; 8'h7f: r = 8'hd2;
			8'h80: r = 8'hcd; 8'h81: r = 8'h0c; 8'h82: r = 8'h13; 8'h83: r = 8'hec;
			8'h84: r = 8'h5f; 8'h85: r = 8'h97; 8'h86: r = 8'h44; 8'h87: r = 8'h17;
			8'h88: r = 8'hc4; 8'h89: r = 8'ha7; 8'h8a: r = 8'h7e; 8'h8b: r = 8'h3d;
			8'h8c: r = 8'h64; 8'h8d: r = 8'h5d; 8'h8e: r = 8'h19; 8'h8f: r = 8'h73;
			8'h90: r = 8'h60; 8'h91: r = 8'h81; 8'h92: r = 8'h4f; 8'h93: r = 8'hdc;
			8'h94: r = 8'h22; 8'h95: r = 8'h2a; 8'h96: r = 8'h90; 8'h97: r = 8'h88;
			8'h98: r = 8'h46; 8'h99: r = 8'hee; 8'h9a: r = 8'hb8; 8'h9b: r = 8'h14;
			8'h9c: r = 8'hde; 8'h9d: r = 8'h5e; 8'h9e: r = 8'h0b; 8'h9f: r = 8'hdb;
			8'ha0: r = 8'he0; 8'ha1: r = 8'h32; 8'ha2: r = 8'h3a; 8'ha3: r = 8'h0a;
			8'ha4: r = 8'h49; 8'ha5: r = 8'h06; 8'ha6: r = 8'h24; 8'ha7: r = 8'h5c;
			8'ha8: r = 8'hc2; 8'ha9: r = 8'hd3; 8'haa: r = 8'hac; 8'hab: r = 8'h62;
			8'hac: r = 8'h91; 8'had: r = 8'h95; 8'hae: r = 8'he4; 8'haf: r = 8'h79;
			8'hb0: r = 8'he7; 8'hb1: r = 8'hc8; 8'hb2: r = 8'h37; 8'hb3: r = 8'h6d;
			8'hb4: r = 8'h8d; 8'hb5: r = 8'hd5; 8'hb6: r = 8'h4e; 8'hb7: r = 8'ha9;
			8'hb8: r = 8'h6c; 8'hb9: r = 8'h56; 8'hba: r = 8'hf4; 8'hbb: r = 8'hea;
			8'hbc: r = 8'h65; 8'hbd: r = 8'h7a; 8'hbe: r = 8'hae; 8'hbf: r = 8'h08;
			8'hc0: r = 8'hba; 8'hc1: r = 8'h78; 8'hc2: r = 8'h25; 8'hc3: r = 8'h2e;
			8'hc4: r = 8'h1c; 8'hc5: r = 8'ha6; 8'hc6: r = 8'hb4; 8'hc7: r = 8'hc6;
			8'hc8: r = 8'he8; 8'hc9: r = 8'hdd; 8'hca: r = 8'h74; 8'hcb: r = 8'h1f;
			8'hcc: r = 8'h4b; 8'hcd: r = 8'hbd; 8'hce: r = 8'h8b; 8'hcf: r = 8'h8a;
			8'hd0: r = 8'h70; 8'hd1: r = 8'h3e; 8'hd2: r = 8'hb5; 8'hd3: r = 8'h66;
			8'hd4: r = 8'h48; 8'hd5: r = 8'h03; 8'hd6: r = 8'hf6; 8'hd7: r = 8'h0e;
			8'hd8: r = 8'h61; 8'hd9: r = 8'h35; 8'hda: r = 8'h57; 8'hdb: r = 8'hb9;
			8'hdc: r = 8'h86; 8'hdd: r = 8'hc1; 8'hde: r = 8'h1d; 8'hdf: r = 8'h9e;
			8'he0: r = 8'he1; 8'he1: r = 8'hf8; 8'he2: r = 8'h98; 8'he3: r = 8'h11;
			8'he4: r = 8'h69; 8'he5: r = 8'hd9; 8'he6: r = 8'h8e; 8'he7: r = 8'h94;
			8'he8: r = 8'h9b; 8'he9: r = 8'h1e; 8'hea: r = 8'h87; 8'heb: r = 8'he9;
			8'hec: r = 8'hce; 8'hed: r = 8'h55; 8'hee: r = 8'h28; 8'hef: r = 8'hdf;
			8'hf0: r = 8'h8c; 8'hf1: r = 8'ha1; 8'hf2: r = 8'h89; 8'hf3: r = 8'h0d;
			8'hf4: r = 8'hbf; 8'hf5: r = 8'he6; 8'hf6: r = 8'h42; 8'hf7: r = 8'h68;
			8'hf8: r = 8'h41; 8'hf9: r = 8'h99; 8'hfa: r = 8'h2d; 8'hfb: r = 8'h0f;
			8'hfc: r = 8'hb0; 8'hfd: r = 8'h54; 8'hfe: r = 8'hbb; 8'hff: r = 8'h16;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic byte_t xtime(input byte_t v);
		return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
	endfunction

	// Byte i of a block sits at bits [127-8i -: 8].
	function automatic byte_t get_byte(input block_t b, input int i);
		return b[BlockWidth-1-8*i -: 8];
	endfunction

	function automatic block_t sub_shift(input block_t st);
		block_t t;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				t[BlockWidth-1-8*(r+4*c) -: 8] = sbox(get_byte(st, r + 4*((c + r) & 3)));
			end
		end
		return t;
	endfunction

	function automatic block_t mix_columns(input block_t st);
		block_t t;
		byte_t a0, a1, a2, a3, all;
		for (int c = 0; c < 4; c++) begin
			a0 = get_byte(st, 4*c);
			a1 = get_byte(st, 4*c+1);
			a2 = get_byte(st, 4*c+2);
			a3 = get_byte(st, 4*c+3);
			all = a0 ^ a1 ^ a2 ^ a3;
			t[BlockWidth-1-8*(4*c) -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
			t[BlockWidth-1-8*(4*c+1) -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
			t[BlockWidth-1-8*(4*c+2) -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
			t[BlockWidth-1-8*(4*c+3) -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
		end
		return t;
	endfunction

	// One step of the key schedule: word-wise prefix XOR with RotWord/SubWord.
	function automatic block_t next_key(input block_t rk, input byte_t rcon);
		logic [31:0] t, w0, w1, w2, w3;
		t = {sbox(get_byte(rk, 13)) ^ rcon, sbox(get_byte(rk, 14)),
			sbox(get_byte(rk, 15)), sbox(get_byte(rk, 12))};
		w0 = rk[127:96] ^ t;
		w1 = rk[95:64] ^ w0;
		w2 = rk[63:32] ^ w1;
		w3 = rk[31:0] ^ w2;
		return {w0, w1, w2, w3};
	endfunction

	// Round constant used to derive the key of round n (n from 1).
	function automatic byte_t rcon_of(input int n);
		byte_t r;
		r = 8'h01;
		for (int i = 1; i < 16; i++) begin
			if (i < n) begin
				r = xtime(r);
			end
		end
		return r;
	endfunction

endpackage

### src/aes_round.sv
// One cipher round per instance: state and round key advance together.
module aes_round #(
	parameter int RoundIndex = 1,
	parameter bit FinalRound = 1'b0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               advance,
	input  logic               valid_in,
	input  aes_pkg::block_t    state_in,
	input  aes_pkg::block_t    key_in,
	output logic               valid_out,
	output aes_pkg::block_t    state_out,
	output aes_pkg::block_t    key_out
);

	localparam aes_pkg::byte_t Rcon = aes_pkg::rcon_of(RoundIndex);

	aes_pkg::block_t mixed;
	aes_pkg::block_t key_next;

	always_comb begin
		key_next = aes_pkg::next_key(key_in, Rcon);
		if (FinalRound) begin
			mixed = aes_pkg::sub_shift(state_in);
		end else begin
			mixed = aes_pkg::mix_columns(aes_pkg::sub_shift(state_in));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out <= 1'b0;
		end else if (advance) begin
			valid_out <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_in) begin
			state_out <= mixed ^ key_next;
			key_out <= key_next;
		end
	end

endmodule

### src/aes128_block_encrypt.sv
// Channel   Handshake              Payload
// input     in_valid / in_ready    plain_high, plain_low
// output    out_valid / out_ready  cipher_high, cipher_low
// config    APB write/read         key_high (0x0), key_low (0x8)
//
// The pipeline has one stage for the initial AddRoundKey and one stage per round,
// each holding the state and the round key derived for it.
// One transaction is accepted per cycle; the pipeline advances as a whole whenever
// the last stage is empty or its result is being taken, so a stall freezes all stages.
// Reset clears every valid bit and both key registers to zero.
module aes128_block_encrypt #(
	parameter int ROUND_COUNT = aes_pkg::RoundCountDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] plain_high,
	input  logic [63:0] plain_low,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] cipher_high,
	output logic [63:0] cipher_low,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);

	logic [63:0] key_high_q;
	logic [63:0] key_low_q;
	logic        reg_sel;

	// Register index is the address divided by eight.
	assign reg_sel = paddr[3];
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q <= '0;
		end else if (psel && penable && pwrite && (paddr[2:0] == 3'b000)) begin
			case (reg_sel)
				aes_pkg::RegKeyHigh: key_high_q <= pwdata;
				aes_pkg::RegKeyLow: key_low_q <= pwdata;
				default: key_high_q <= key_high_q;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			aes_pkg::RegKeyHigh: prdata = key_high_q;
			aes_pkg::RegKeyLow: prdata = key_low_q;
			default: prdata = '0;
		endcase
	end

	// Whole-pipeline advance: the last stage either is empty or hands off now.
	logic advance;
	assign advance = !out_valid || out_ready;
	assign in_ready = advance;

	// Stage 0 holds the state after the initial AddRoundKey, and the cipher key.
	logic                  valid_s [ROUND_COUNT+1];
	aes_pkg::block_t       state_s [ROUND_COUNT+1];
	aes_pkg::block_t       key_s   [ROUND_COUNT+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s[0] <= 1'b0;
		end else if (advance) begin
			valid_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_valid) begin
			state_s[0] <= {plain_high, plain_low} ^ {key_high_q, key_low_q};
			key_s[0] <= {key_high_q, key_low_q};
		end
	end

	for (genvar g = 1; g <= ROUND_COUNT; g++) begin : g_round
		aes_round #(
			.RoundIndex(g),
			.FinalRound(g == ROUND_COUNT)
		) u_round (
			.clk(clk),
			.arst_n(arst_n),
			.advance(advance),
			.valid_in(valid_s[g-1]),
			.state_in(state_s[g-1]),
			.key_in(key_s[g-1]),
			.valid_out(valid_s[g]),
			.state_out(state_s[g]),
			.key_out(key_s[g])
		);
	end

	assign out_valid = valid_s[ROUND_COUNT];
	assign cipher_high = state_s[ROUND_COUNT][127:64];
	assign cipher_low = state_s[ROUND_COUNT][63:0];

	// A stalled result must hold until it is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(cipher_high) && $stable(cipher_low))
		else $error("result changed while stalled");

	// While the output stalls, no new transaction enters.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input accepted during output stall");

	// An accepted transaction has entered the first stage at the next edge.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> valid_s[0])
		else $error("accepted transaction lost in first stage");

endmodule

### dv/aes128_block_encrypt_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the AES-128 block encryption pipeline.
// An initial block programs the key over the APB-style port and fills a queue of
// plaintext blocks. A clocked driver presents them on the input channel, and a
// clocked monitor compares every ciphertext transaction with the oldest prediction.
module aes128_block_encrypt_tb;

	typedef struct packed {
		logic [63:0] hi;
		logic [63:0] lo;
	} half_pair_t;

	// Register byte addresses: 64-bit registers sit at 8*index.
	localparam logic [3:0] AddrKeyHigh = 4'(8 * aes_pkg::RegKeyHigh);
	localparam logic [3:0] AddrKeyLow = 4'(8 * aes_pkg::RegKeyLow);
	localparam int StallLimit = 2000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [63:0] plain_high;
	logic [63:0] plain_low;
	logic out_valid;
	logic out_ready;
	logic [63:0] cipher_high;
	logic [63:0] cipher_low;
	logic psel;
	logic penable;
	logic pwrite;
	logic [3:0] paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic pready;

	aes128_block_encrypt uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.plain_high(plain_high), .plain_low(plain_low),
		.out_valid(out_valid), .out_ready(out_ready),
		.cipher_high(cipher_high), .cipher_low(cipher_low),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// Shadow copy of the key registers, updated as each write completes.
	logic [63:0] key_hi_shadow;
	logic [63:0] key_lo_shadow;

	half_pair_t plain_queue[$];
	half_pair_t cipher_expected[$];
	bit failed;
	bit idle_enable;
	bit in_taken;
	int quiet_cycles;

	// S-box built from the multiplicative inverse in GF(2^8) and the affine map,
	// so the prediction does not lean on the package's own table.
	logic [7:0] sub_table[256];

	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] p;
		p = 8'h00;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) begin
				p ^= a;
			end
			a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
		end
		return p;
	endfunction

	initial begin
		logic [7:0] inv, s;
		for (int v = 0; v < 256; v++) begin
			inv = 8'h00;
			for (int w = 1; w < 256; w++) begin
				if (gf_mul(8'(v), 8'(w)) == 8'h01) begin
					inv = 8'(w);
				end
			end
			s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
				^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
			sub_table[v] = s;
		end
	end

	function automatic logic [7:0] dbl(input logic [7:0] v);
		return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
	endfunction

	// Full AES-128 encryption on a byte array; byte 0 is the top byte of the block.
	function automatic half_pair_t encrypt_block(input half_pair_t pt, input half_pair_t key);
		logic [7:0] st[16];
		logic [7:0] rk[16];
		logic [7:0] tmp[16];
		logic [7:0] tw[4];
		logic [7:0] rc;
		logic [7:0] a0, a1, a2, a3, sum;
		logic [127:0] pt_flat, key_flat, out_flat;
		pt_flat = pt;
		key_flat = key;
		rc = 8'h01;
		for (int i = 0; i < 16; i++) begin
			st[i] = pt_flat[127-8*i -: 8] ^ key_flat[127-8*i -: 8];
			rk[i] = key_flat[127-8*i -: 8];
		end
		for (int rnd = 1; rnd <= 10; rnd++) begin
			for (int c = 0; c < 4; c++) begin
				for (int r = 0; r < 4; r++) begin
					tmp[r+4*c] = sub_table[st[r + 4*((c + r) % 4)]];
				end
			end
			st = tmp;
			if (rnd < 10) begin
				for (int c = 0; c < 4; c++) begin
					a0 = st[4*c];
					a1 = st[4*c+1];
					a2 = st[4*c+2];
					a3 = st[4*c+3];
					sum = a0 ^ a1 ^ a2 ^ a3;
					st[4*c] = a0 ^ sum ^ dbl(a0 ^ a1);
					st[4*c+1] = a1 ^ sum ^ dbl(a1 ^ a2);
					st[4*c+2] = a2 ^ sum ^ dbl(a2 ^ a3);
					st[4*c+3] = a3 ^ sum ^ dbl(a3 ^ a0);
				end
			end
			tw[0] = sub_table[rk[13]] ^ rc;
			tw[1] = sub_table[rk[14]];
			tw[2] = sub_table[rk[15]];
			tw[3] = sub_table[rk[12]];
			for (int i = 0; i < 16; i++) begin
				rk[i] ^= tw[i % 4];
				tw[i % 4] = rk[i];
			end
			rc = dbl(rc);
			for (int i = 0; i < 16; i++) begin
				st[i] ^= rk[i];
			end
		end
		for (int i = 0; i < 16; i++) begin
			out_flat[127-8*i -: 8] = st[i];
		end
		return out_flat;
	endfunction

	// Driver: a new block is raised only after the previous one was taken at the
	// last rising edge, and valid stays up with a stable payload until then.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_taken) begin
				if (plain_queue.size() > 0 && (!idle_enable || $urandom_range(99) >= 29)) begin
					in_valid <= 1'b1;
					plain_high <= plain_queue[0].hi;
					plain_low <= plain_queue[0].lo;
					void'(plain_queue.pop_front());
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_ready <= !idle_enable || ($urandom_range(99) >= 29);
		end
	end

	// Monitor: predictions are made when a block is accepted, using the key in
	// force at that moment, and checked in order against the output stream.
	always @(posedge clk) begin
		half_pair_t want;
		if (arst_n) begin
			in_taken <= in_valid && in_ready;
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
			if (in_valid && in_ready) begin
				cipher_expected.push_back(encrypt_block({plain_high, plain_low},
					{key_hi_shadow, key_lo_shadow}));
			end
			if (psel && penable && pwrite && pready) begin
				if (paddr == AddrKeyHigh) begin
					key_hi_shadow <= pwdata;
				end else if (paddr == AddrKeyLow) begin
					key_lo_shadow <= pwdata;
				end
			end
			if (out_valid && out_ready) begin
				if (cipher_expected.size() == 0) begin
					$display("%0t: unexpected ciphertext %h %h", $time, cipher_high, cipher_low);
					failed = 1'b1;
				end else begin
					want = cipher_expected.pop_front();
					if (cipher_high !== want.hi) begin
						$display("%0t: cipher_high expected %h actual %h",
							$time, want.hi, cipher_high);
						failed = 1'b1;
					end
					if (cipher_low !== want.lo) begin
						$display("%0t: cipher_low expected %h actual %h",
							$time, want.lo, cipher_low);
						failed = 1'b1;
					end
				end
			end
			if (quiet_cycles > StallLimit) begin
				$display("aes128_block_encrypt test failed");
				$finish;
			end
		end
	end

	task automatic apb_write(input logic [3:0] addr, input logic [63:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_key(input logic [63:0] hi, input logic [63:0] lo);
		apb_write(AddrKeyHigh, hi);
		apb_write(AddrKeyLow, lo);
	endtask

	// Lets the pipeline empty before the key is touched again.
	task automatic drain_pipeline();
		while (plain_queue.size() > 0 || in_valid || cipher_expected.size() > 0) begin
			@(negedge clk);
		end
		repeat (20) @(negedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic queue_block(input logic [63:0] hi, input logic [63:0] lo);
		half_pair_t blk;
		blk.hi = hi;
		blk.lo = lo;
		plain_queue.push_back(blk);
	endtask

	initial begin
		in_valid = 1'b0;
		plain_high = '0;
		plain_low = '0;
		out_ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		key_hi_shadow = '0;
		key_lo_shadow = '0;
		failed = 1'b0;
		idle_enable = 1'b0;
		in_taken = 1'b0;
		quiet_cycles = 0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// The key has never been written, so the all-zero reset key applies.
		queue_block('0, '0);
		queue_block('1, '1);
		drain_pipeline();

		// The FIPS-197 example key and plaintext, then the field extremes,
		// back to back with no idling.
		set_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
		queue_block(64'h0011223344556677, 64'h8899aabbccddeeff);
		queue_block('0, '0);
		queue_block('1, '1);
		queue_block('1, '0);
		queue_block('0, '1);
		queue_block(64'h8000000000000000, 64'h0000000000000001);
		queue_block(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
		drain_pipeline();
		set_key('1, '1);
		queue_block('0, '0);
		queue_block('1, '1);
		queue_block(64'h0011223344556677, 64'h8899aabbccddeeff);
		drain_pipeline();
		queue_block(rand64(), rand64());
		drain_pipeline();

		// Random phases: random gaps in every phase but the second, which runs without
		// idling, each phase under its own key, with the extreme keys among them.
		for (int phase = 0; phase < 9; phase++) begin
			idle_enable = (phase != 1);
			case (phase)
				2: set_key('0, '0);
				5: set_key('1, '0);
				default: set_key(rand64(), rand64());
			endcase
			for (int n = 0; n < 100; n++) begin
				queue_block(rand64(), rand64());
			end
			drain_pipeline();
		end

		if (!failed) begin
			$display("aes128_block_encrypt test passed");
		end else begin
			$display("aes128_block_encrypt test failed");
		end
		$finish;
	end

endmodule
